// ===== rtl/percentile_histogram_stretch_core_macros.svh =====
// Assertion helpers for the stretch core
`ifndef PERCENTILE_HISTOGRAM_STRETCH_CORE_MACROS_SVH
`define PERCENTILE_HISTOGRAM_STRETCH_CORE_MACROS_SVH

// same-cycle implication
`define PHS_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define PHS_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/phs_pkg.sv =====
package phs_pkg;
    localparam int MAX_PIXELS_DEF = 4194304;
    localparam int BINS           = 256;
    localparam int PCT_W          = 13;
    localparam logic [PCT_W-1:0] PCT_CAP   = 13'd5000;
    localparam logic [PCT_W-1:0] PCT_RESET = 13'd100;
    localparam int PCT_SCALE      = 10000;
    localparam int NCH            = 3;

    typedef struct packed {
        logic       busy;
        logic [7:0] q;
        logic [7:0] r;
    } t_div_out;
endpackage

// ===== rtl/phs_ram.sv =====
module phs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/phs_div.sv =====
module phs_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [15:0]          i_num,
    input  logic [7:0]           i_den,
    output phs_pkg::t_div_out    o_res
);
    import phs_pkg::*;

    logic [7:0]  r_rem;
    logic [15:0] r_quo;
    logic [7:0]  r_den;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic [8:0]  n_sh;

    // restoring division, one quotient bit per cycle
    assign n_sh = {r_rem, r_quo[15]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_quo  <= i_num;
            r_den  <= i_den;
        end else if (r_busy) begin
            if (n_sh >= {1'b0, r_den}) begin
                r_rem <= 8'(n_sh - {1'b0, r_den});
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= n_sh[7:0];
                r_quo <= {r_quo[14:0], 1'b0};
            end
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.q    = r_quo[7:0];
    assign o_res.r    = r_rem;
endmodule

// ===== rtl/percentile_histogram_stretch_core.sv =====
// Percentile contrast stretch core for 8-bit BGR pixels.
// Input stream (s): tdata = blue, green, red; tuser = op (0 collect,
// 1 stretch); tlast = frame end on the final collect pixel.
// Output stream (m): tuser = kind (0 stretched pixel, 1 bounds report);
// tdata = stretched b/g/r then b lo/hi, g lo/hi, r lo/hi.
// Config: i_cfg_we/i_cfg_wdata write the tail percentile (hundredths of %).
// Collect pixel: a read-modify-write on the three histogram RAMs (registered
// read, write in S_WR), no result; the next transfer is taken after S_WR.
// Collect pixel with frame end: the write state S_WR, then a bin scan (256
// bins upward, 256 downward clearing each bin as it is read, then a pipeline
// drain), then S_RND latches the bounds and S_FIN loads the output register
// with the report; the next input is taken after S_FIN.
// Stretch pixel: S_DIV waits on the bit-serial dividers, S_RND rounds, and
// S_FIN loads the output register with the result; the next input is taken
// after S_FIN.
// The output register holds one result; the block takes the next input
// while it waits and stalls in its last step only when a second result
// has nowhere to go.
// Reset runs a clearing pass over all 256 bins (s_tready low); then
// the count is zero, the bounds low 0 / high 255 and the percentile 100.
module percentile_histogram_stretch_core #(
    parameter int MAX_PIXELS = phs_pkg::MAX_PIXELS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // blue_in, green_in, red_in
    input  logic        i_s_tuser,   // op
    input  logic        i_s_tlast,   // frame_end
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // blue_out, green_out, red_out, blue_low,
                                     // blue_high, green_low, green_high,
                                     // red_low, red_high
    output logic        o_m_tuser,   // kind
    input  logic        i_cfg_we,
    input  logic [phs_pkg::PCT_W-1:0] i_cfg_wdata
);
    import phs_pkg::*;

    localparam int CW = $clog2(MAX_PIXELS + 1);   // count and bin width
    localparam int TW = CW + 14;                  // product width
    localparam logic [CW-1:0] MAXC = CW'(MAX_PIXELS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_RND  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;
    localparam logic [2:0] S_CLR  = 3'd6;

    logic [2:0]       r_st;
    logic [PCT_W-1:0] r_pct;
    logic [CW-1:0]    r_cnt;
    logic [7:0]       r_lo [NCH];
    logic [7:0]       r_hi [NCH];
    logic [7:0]       r_nlo [NCH];
    logic [7:0]       r_nhi [NCH];
    logic [7:0]       r_px [NCH];
    logic             r_fe;
    logic             r_kind;
    logic [7:0]       r_res [NCH];
    logic [9:0]       r_sc;      // scan / clear counter
    logic [8:0]       r_scd;     // index being processed
    logic             r_scv;
    logic [CW-1:0]    r_cum [NCH];
    logic             r_fnd [NCH];
    logic [TW-1:0]    r_tgt;
    logic             r_ov;
    logic [71:0]      r_od;
    logic             r_ou;

    logic [7:0]       n_raddr;
    logic [CW-1:0]    rdata [NCH];
    logic [CW-1:0]    n_bin [NCH];
    logic             n_inc;
    logic             n_we;
    t_div_out         dres [NCH];
    logic [15:0]      n_num [NCH];
    logic [7:0]       n_den [NCH];
    logic [7:0]       n_v [NCH];
    logic             acc;
    logic [PCT_W-1:0] pcap;

    assign o_s_tready = (r_st == S_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign pcap       = (r_pct > PCT_CAP) ? PCT_CAP : r_pct;
    assign n_inc      = (r_st == S_WR) && (r_cnt < MAXC);
    // bin update, clearing pass, and zeroing each bin on the downward scan
    assign n_we       = n_inc || (r_st == S_CLR) || ((r_st == S_SCAN) && r_sc[8]);

    // bin index during the scan and the clearing pass
    always_comb begin
        if (r_sc[8]) begin
            n_raddr = ~r_sc[7:0];
        end else begin
            n_raddr = r_sc[7:0];
        end
    end

    for (genvar c = 0; c < NCH; c++) begin : g_ch
        logic [7:0] ra;
        logic [7:0] wa;
        assign ra = (r_st == S_SCAN) ? n_raddr : i_s_tdata[8*c +: 8];
        assign wa = (r_st == S_WR) ? r_px[c] : n_raddr;
        assign n_bin[c] = (r_st == S_WR) ? rdata[c] + CW'(1) : '0;

        phs_ram #(.WIDTH(CW), .DEPTH(BINS)) u_hist (
            .i_clk   (i_clk),
            .i_we    (n_we),
            .i_waddr (wa),
            .i_wdata (n_bin[c]),
            .i_raddr (ra),
            .o_rdata (rdata[c])
        );

        // clip, then scale numerator and span for the divider
        always_comb begin
            n_v[c] = i_s_tdata[8*c +: 8];
            if (n_v[c] < r_lo[c]) n_v[c] = r_lo[c];
            if (n_v[c] > r_hi[c]) n_v[c] = r_hi[c];
            n_num[c] = 16'(n_v[c] - r_lo[c]) * 16'd255;
            n_den[c] = r_hi[c] - r_lo[c];
        end

        phs_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (acc && i_s_tuser),
            .i_num   (n_num[c]),
            .i_den   (n_den[c]),
            .o_res   (dres[c])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_pct  <= PCT_RESET;
            r_cnt  <= '0;
            r_ov   <= 1'b0;
            r_sc   <= '0;
            r_scv  <= 1'b0;
            for (int c = 0; c < NCH; c++) begin
                r_lo[c]  <= 8'd0;
                r_hi[c]  <= 8'd255;
            end
        end else begin
            if (i_cfg_we) r_pct <= i_cfg_wdata;
            if (r_st == S_FIN && (!r_ov || i_m_tready)) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                S_CLR: begin
                    r_sc <= r_sc + 10'd1;
                    if (r_sc[7:0] == 8'hFF) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (acc) begin
                        for (int c = 0; c < NCH; c++) r_px[c] <= i_s_tdata[8*c +: 8];
                        r_fe <= i_s_tlast;
                        r_st <= i_s_tuser ? S_DIV : S_WR;
                    end
                end
                S_WR: begin
                    if (n_inc) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_sc  <= '0;
                    r_scv <= 1'b0;
                    r_st  <= r_fe ? S_SCAN : S_IDLE;
                end
                S_SCAN: begin
                    if (r_sc == 10'd0) begin
                        r_tgt <= TW'(pcap) * TW'(r_cnt);
                    end
                    if (!r_sc[9]) r_sc <= r_sc + 10'd1;
                    r_scv <= !r_sc[9];
                    r_scd <= r_sc[8:0];
                    if (r_scv) begin
                        for (int c = 0; c < NCH; c++) begin
                            logic [CW-1:0] cum;
                            logic          hit;
                            logic          first;
                            first = (r_scd[7:0] == 8'd0);
                            cum   = (first ? '0 : r_cum[c]) + rdata[c];
                            hit   = (TW'(cum) * TW'(PCT_SCALE)) >= r_tgt;
                            r_cum[c] <= cum;
                            if (first || !r_fnd[c]) begin
                                r_fnd[c] <= hit;
                                if (r_scd[8]) begin
                                    if (hit) r_nhi[c] <= ~r_scd[7:0];
                                    else if (first) r_nhi[c] <= 8'd0;
                                end else begin
                                    if (hit) r_nlo[c] <= r_scd[7:0];
                                    else if (first) r_nlo[c] <= 8'd255;
                                end
                            end
                        end
                        if (r_scd == 9'h1FF) begin
                            r_cnt  <= '0;
                            r_kind <= 1'b1;
                            r_st   <= S_RND;
                        end
                    end
                end
                S_DIV: begin
                    r_kind <= 1'b0;
                    if (!dres[0].busy) r_st <= S_RND;
                end
                S_RND: begin
                    if (r_kind) begin
                        for (int c = 0; c < NCH; c++) begin
                            r_lo[c]  <= r_nlo[c];
                            r_hi[c]  <= r_nhi[c];
                            r_res[c] <= 8'd0;
                        end
                    end else begin
                        for (int c = 0; c < NCH; c++) begin
                            logic [8:0] r2;
                            logic [8:0] q;
                            r2 = {dres[c].r, 1'b0};
                            q  = {1'b0, dres[c].q};
                            if (r2 > {1'b0, n_den[c]} ||
                                (r2 == {1'b0, n_den[c]} && q[0])) q = q + 9'd1;
                            if (r_hi[c] <= r_lo[c]) r_res[c] <= 8'd0;
                            else r_res[c] <= q[8] ? 8'd255 : q[7:0];
                        end
                    end
                    r_st <= S_FIN;
                end
                S_FIN: begin
                    if (!r_ov || i_m_tready) begin
                        r_ou <= r_kind;
                        r_od <= {r_hi[2], r_lo[2], r_hi[1], r_lo[1], r_hi[0], r_lo[0],
                                 r_res[2], r_res[1], r_res[0]};
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_od;
    assign o_m_tuser  = r_ou;

`include "percentile_histogram_stretch_core_macros.svh"

    `PHS_ASSERT_NOW(a_cnt_cap, i_clk, i_rst_n, 1'b1, r_cnt <= MAXC, "pixel count over cap")
    `PHS_ASSERT_NOW(a_idle_div, i_clk, i_rst_n, o_s_tready, !dres[0].busy, "divider busy in idle")
    `PHS_ASSERT_NOW(a_bounds, i_clk, i_rst_n, o_m_tvalid && o_m_tuser,
                    o_m_tdata[31:24] <= o_m_tdata[39:32], "blue low above high")
    `PHS_ASSERT_NEXT(a_fe_scan, i_clk, i_rst_n, r_st == S_WR && r_fe, r_st == S_SCAN,
                     "frame end without scan")
endmodule
